// ----- design/miv_pkg.sv -----
`default_nettype none
package miv_pkg;

  localparam int NUM_WIDTH = 32;
  localparam int CNT_W     = $clog2(NUM_WIDTH);

  typedef logic [NUM_WIDTH-1:0] num_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_TAIL,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RES_COEF,
    RES_ONE,
    RES_BAD
  } res_kind_e;

  typedef struct packed {
    logic      load;
    logic      div_clear;
    logic      div_step;
    logic      acc_tail;
    logic      update;
    logic      capture;
    res_kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic m_one;
    logic m_zero;
    logic a_zero;
    logic a_gt1;
    logic b_zero;
  } stat_t;

endpackage
`default_nettype wire

// ----- design/miv_datapath.sv -----
`default_nettype none
module miv_datapath (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            modulus_we_i,
  input  miv_pkg::num_t  modulus_i,
  input  miv_pkg::num_t  value_i,
  input  miv_pkg::cmd_t  cmd_i,
  output miv_pkg::stat_t stat_o,
  output miv_pkg::num_t  inverse_o,
  output logic           not_invertible_o
);
  import miv_pkg::*;

  num_t modulus_q;
  num_t a_q, b_q, rem_q, dvd_q, acc_q, magc_q, magp_q;
  logic qbit_q, neg_q;
  num_t inverse_q;
  logic bad_q;

  logic [NUM_WIDTH:0] shifted;
  logic [NUM_WIDTH:0] diff;
  logic               fits;
  num_t               acc_next;
  num_t               coef;

  // One restoring division step; the registered quotient bit feeds the serial multiply in the next step.
  assign shifted  = {rem_q, dvd_q[NUM_WIDTH-1]};
  assign diff     = shifted - {1'b0, b_q};
  assign fits     = ~diff[NUM_WIDTH];
  assign acc_next = {acc_q[NUM_WIDTH-2:0], 1'b0} + (qbit_q ? magp_q : '0);
  assign coef     = (neg_q && (magc_q != '0)) ? (modulus_q - magc_q) : magc_q;

  assign stat_o.m_one  = (modulus_q == num_t'(1));
  assign stat_o.m_zero = (modulus_q == '0);
  assign stat_o.a_zero = (a_q == '0);
  assign stat_o.a_gt1  = (a_q[NUM_WIDTH-1:1] != '0);
  assign stat_o.b_zero = (b_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= num_t'(1);
    end else if (modulus_we_i) begin
      modulus_q <= modulus_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= value_i;
      b_q    <= modulus_q;
      magc_q <= num_t'(1);
      magp_q <= '0;
      neg_q  <= 1'b0;
    end
    if (cmd_i.div_clear) begin
      rem_q  <= '0;
      dvd_q  <= a_q;
      acc_q  <= '0;
      qbit_q <= 1'b0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= fits ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
      dvd_q  <= {dvd_q[NUM_WIDTH-2:0], 1'b0};
      qbit_q <= fits;
      acc_q  <= acc_next;
    end
    if (cmd_i.acc_tail) begin
      acc_q <= acc_next;
    end
    if (cmd_i.update) begin
      a_q    <= b_q;
      b_q    <= rem_q;
      magc_q <= magp_q;
      magp_q <= acc_q + magc_q;
      neg_q  <= ~neg_q;
    end
    if (cmd_i.capture) begin
      case (cmd_i.kind)
        RES_ONE: begin
          inverse_q <= num_t'(1);
          bad_q     <= 1'b0;
        end
        RES_BAD: begin
          inverse_q <= '0;
          bad_q     <= 1'b1;
        end
        default: begin
          inverse_q <= coef;
          bad_q     <= 1'b0;
        end
      endcase
    end
  end

  assign inverse_o        = inverse_q;
  assign not_invertible_o = bad_q;

endmodule
`default_nettype wire

// ----- design/miv_ctrl.sv -----
`default_nettype none
module miv_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  input  miv_pkg::stat_t stat_i,
  output miv_pkg::cmd_t  cmd_o
);
  import miv_pkg::*;

  state_e    state_q, state_d;
  cnt_t      cnt_q, cnt_d;
  res_kind_e kind_q, kind_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      kind_q      <= RES_COEF;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    cmd_o.kind  = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stat_i.m_one) begin
          kind_d  = RES_ONE;
          state_d = ST_DONE;
        end else if (stat_i.m_zero || stat_i.a_zero) begin
          kind_d  = RES_BAD;
          state_d = ST_DONE;
        end else if (!stat_i.a_gt1) begin
          kind_d  = RES_COEF;
          state_d = ST_DONE;
        end else if (stat_i.b_zero) begin
          kind_d  = RES_BAD;
          state_d = ST_DONE;
        end else begin
          cmd_o.div_clear = 1'b1;
          cnt_d           = '0;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + cnt_t'(1);
        if (cnt_q == cnt_t'(NUM_WIDTH - 1)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // fold in the last quotient bit
        cmd_o.acc_tail = 1'b1;
        state_d        = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_TEST;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- design/modular_inverse.sv -----
`default_nettype none
// Channel   Handshake                 Payload
// config    modulus_we_i              modulus_i
// input     in_valid_i / in_stall_o   value_i
// output    out_valid_o / out_stall_i inverse_o, not_invertible_o
//
// A result is valid after the input transfer once every Euclid step is through; each step
// runs the bit-serial restoring divider that also forms quotient times coefficient one bit
// a cycle. A modulus of 1 or a zero value needs no Euclid step. The next value is taken
// in the cycle after the capture.
// Reset leaves the modulus at 1 and the block idle with no result pending.
// A finished result waits in the output register; the next value is taken meanwhile,
// and the block only holds before its own capture while that register is still stalled.
module modular_inverse (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  modulus_we_i,
  input  miv_pkg::num_t        modulus_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  miv_pkg::num_t        value_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output miv_pkg::num_t        inverse_o,
  output logic                 not_invertible_o
);
  import miv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  miv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  miv_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .modulus_we_i     (modulus_we_i),
    .modulus_i        (modulus_i),
    .value_i          (value_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .inverse_o        (inverse_o),
    .not_invertible_o (not_invertible_o)
  );

endmodule
`default_nettype wire
